// File: hdl/cati_pkg.sv
// shared types, constants and microcode table for the congestion adaptive tx interval block
// used by cati_div and congestion_adaptive_tx_interval_top; no dependencies
package cati_pkg;

    localparam logic [1:0] CMD_EPOCH = 2'd0;
    localparam logic [1:0] CMD_SEEN  = 2'd1;
    localparam logic [1:0] CMD_OWN   = 2'd2;

    localparam logic [1:0] REG_TARGET   = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;
    localparam logic [1:0] REG_JITTER   = 2'd2;

    localparam logic [9:0]  RST_TARGET   = 10'd16;
    localparam logic [11:0] RST_INTERVAL = 12'd875;
    localparam logic [9:0]  RST_JITTER   = 10'd250;

    localparam logic [11:0] IV_MAX      = 12'd4000;
    localparam logic [11:0] IV_SILENT   = 12'd1000;
    localparam logic [11:0] IV_FLOOR    = 12'd150;
    localparam logic [11:0] IV_ZERO_SUB = 12'd50;
    localparam logic [12:0] IV_BIG      = 13'd300;
    localparam logic [9:0]  JIT_FLOOR   = 10'd25;

    localparam logic [4:0] DIV_LAST_SHORT = 5'd11;
    localparam logic [4:0] DIV_LAST_LONG  = 5'd31;

    localparam logic [3:0] OP_NOP   = 4'd0;
    localparam logic [3:0] OP_CMP   = 4'd1;
    localparam logic [3:0] OP_HALVE = 4'd2;
    localparam logic [3:0] OP_TRIM  = 4'd3;
    localparam logic [3:0] OP_DIVQ  = 4'd4;
    localparam logic [3:0] OP_DIVM  = 4'd5;
    localparam logic [3:0] OP_MINQ  = 4'd6;
    localparam logic [3:0] OP_MIN1K = 4'd7;
    localparam logic [3:0] OP_MIN4K = 4'd8;
    localparam logic [3:0] OP_CLAMP = 4'd9;
    localparam logic [3:0] OP_MUL   = 4'd10;
    localparam logic [3:0] OP_DIVP  = 4'd11;
    localparam logic [3:0] OP_SCALE = 4'd12;
    localparam logic [3:0] OP_FIN   = 4'd13;

    localparam logic [2:0] C_NEXT    = 3'd0;
    localparam logic [2:0] C_JMP     = 3'd1;
    localparam logic [2:0] C_CMPF    = 3'd2;
    localparam logic [2:0] C_PEERS0  = 3'd3;
    localparam logic [2:0] C_BUSY    = 3'd4;
    localparam logic [2:0] C_QZERO   = 3'd5;
    localparam logic [2:0] C_OUTBUSY = 3'd6;

    localparam logic [1:0] FLAG_NONE = 2'd0;
    localparam logic [1:0] FLAG_80   = 2'd1;
    localparam logic [1:0] FLAG_50   = 2'd2;
    localparam logic [1:0] FLAG_90   = 2'd3;

    localparam logic [4:0] L_START = 5'd0;
    localparam logic [4:0] L_TRIM  = 5'd3;
    localparam logic [4:0] L_WAITQ = 5'd8;
    localparam logic [4:0] L_WAITM = 5'd10;
    localparam logic [4:0] L_MIN1K = 5'd12;
    localparam logic [4:0] L_MIN4K = 5'd13;
    localparam logic [4:0] L_CLAMP = 5'd14;
    localparam logic [4:0] L_HIGH  = 5'd15;
    localparam logic [4:0] L_WAITP = 5'd18;
    localparam logic [4:0] L_FIN   = 5'd20;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] cond;
        logic [4:0] target;
        logic [6:0] ka;
        logic [6:0] kb;
        logic       gt;
        logic [1:0] flag;
    } t_uword;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [12:0] divisor;
        logic [4:0]  last;
    } t_div_req;

    function automatic t_uword uw(input logic [3:0] op, input logic [2:0] cond,
                                  input logic [4:0] target, input logic [6:0] ka,
                                  input logic [6:0] kb, input logic gt,
                                  input logic [1:0] flag);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        w.ka     = ka;
        w.kb     = kb;
        w.gt     = gt;
        w.flag   = flag;
        return w;
    endfunction

    function automatic t_uword ucode(input logic [4:0] pc);
        t_uword w;
        case (pc)
            5'd0:  w = uw(OP_CMP,   C_CMPF,    L_HIGH,  7'd100, 7'd95, 1'b0, FLAG_NONE);
            5'd1:  w = uw(OP_CMP,   C_CMPF,    L_TRIM,  7'd4,   7'd1,  1'b0, FLAG_NONE);
            5'd2:  w = uw(OP_HALVE, C_JMP,     L_FIN,   7'd0,   7'd0,  1'b0, FLAG_NONE);
            5'd3:  w = uw(OP_CMP,   C_NEXT,    L_START, 7'd5,   7'd4,  1'b0, FLAG_80);
            5'd4:  w = uw(OP_CMP,   C_NEXT,    L_START, 7'd2,   7'd1,  1'b0, FLAG_50);
            5'd5:  w = uw(OP_CMP,   C_NEXT,    L_START, 7'd10,  7'd9,  1'b1, FLAG_90);
            5'd6:  w = uw(OP_TRIM,  C_NEXT,    L_START, 7'd0,   7'd0,  1'b0, FLAG_NONE);
            5'd7:  w = uw(OP_DIVQ,  C_PEERS0,  L_MIN1K, 7'd0,   7'd0,  1'b0, FLAG_NONE);
            5'd8:  w = uw(OP_NOP,   C_BUSY,    L_WAITQ, 7'd0,   7'd0,  1'b0, FLAG_NONE);
            5'd9:  w = uw(OP_DIVM,  C_QZERO,   L_MIN4K, 7'd0,   7'd0,  1'b0, FLAG_NONE);
            5'd10: w = uw(OP_NOP,   C_BUSY,    L_WAITM, 7'd0,   7'd0,  1'b0, FLAG_NONE);
            5'd11: w = uw(OP_MINQ,  C_JMP,     L_CLAMP, 7'd0,   7'd0,  1'b0, FLAG_NONE);
            5'd12: w = uw(OP_MIN1K, C_JMP,     L_CLAMP, 7'd0,   7'd0,  1'b0, FLAG_NONE);
            5'd13: w = uw(OP_MIN4K, C_NEXT,    L_START, 7'd0,   7'd0,  1'b0, FLAG_NONE);
            5'd14: w = uw(OP_CLAMP, C_JMP,     L_FIN,   7'd0,   7'd0,  1'b0, FLAG_NONE);
            5'd15: w = uw(OP_CMP,   C_CMPF,    L_FIN,   7'd1,   7'd1,  1'b1, FLAG_NONE);
            5'd16: w = uw(OP_MUL,   C_NEXT,    L_START, 7'd0,   7'd0,  1'b0, FLAG_NONE);
            5'd17: w = uw(OP_DIVP,  C_NEXT,    L_START, 7'd0,   7'd0,  1'b0, FLAG_NONE);
            5'd18: w = uw(OP_NOP,   C_BUSY,    L_WAITP, 7'd0,   7'd0,  1'b0, FLAG_NONE);
            5'd19: w = uw(OP_SCALE, C_NEXT,    L_START, 7'd0,   7'd0,  1'b0, FLAG_NONE);
            5'd20: w = uw(OP_FIN,   C_OUTBUSY, L_FIN,   7'd0,   7'd0,  1'b0, FLAG_NONE);
            default: w = uw(OP_NOP, C_JMP,     L_FIN,   7'd0,   7'd0,  1'b0, FLAG_NONE);
        endcase
        return w;
    endfunction

endpackage

// File: hdl/congestion_adaptive_tx_interval_top.sv
// congestion adaptive tx interval: counting transactions are accepted back to back while the sequencer is idle
// epoch transaction: microcoded sequencer; the result path is unchanged, halving, trim with
// no active peers, trim with a zero peer share (one 12 step division), the full trim path
// (two 12 step divisions), or scale-up (one 32 step division)
// input stalls while the sequencer runs, including while a stalled result holds it
// synchronous active low reset: counters cleared, target 16, interval 875, jitter 250
module congestion_adaptive_tx_interval_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_active_peers,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_interval_ms,
    output logic [9:0]  o_jitter_ms,
    output logic        o_reset_radio,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data
);

    logic [9:0]         r_target, n_target;
    logic signed [12:0] r_iv, n_iv;
    logic [9:0]         r_jitter, n_jitter;
    logic [15:0]        r_seen, n_seen;
    logic [15:0]        r_own, n_own;
    logic [1:0]         r_silent, n_silent;
    logic [7:0]         r_peers, n_peers;
    logic               r_f80, n_f80;
    logic               r_f50, n_f50;
    logic               r_f90, n_f90;
    logic [11:0]        r_minv, n_minv;
    logic [31:0]        r_prod, n_prod;
    logic               r_run, n_run;
    logic [4:0]         r_pc, n_pc;
    logic               r_ovalid, n_ovalid;
    logic [11:0]        r_oint, n_oint;
    logic [9:0]         r_ojit, n_ojit;
    logic               r_orst, n_orst;

    cati_pkg::t_uword   w_uw;
    cati_pkg::t_div_req w_req;
    logic [31:0]        w_quot;
    logic               w_div_busy;

    logic               w_in_acc;
    logic               w_out_busy;
    logic [9:0]         w_t;
    logic [16:0]        w_s;
    logic [23:0]        w_lhs;
    logic [23:0]        w_rhs;
    logic               w_cmp;
    logic [19:0]        w_lin;
    logic [12:0]        w_t5;
    logic               w_cond;
    logic               w_big;
    logic signed [12:0] w_adj;
    logic [11:0]        w_fin_iv;
    logic [9:0]         w_fin_jit;
    logic [11:0]        w_fin_int;

    assign w_uw       = cati_pkg::ucode(r_pc);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_busy = r_ovalid && i_stall;

    assign w_t   = (r_target == 10'd0) ? 10'd1 : r_target;
    assign w_s   = {1'b0, r_seen} + {1'b0, r_own};
    assign w_lhs = {7'b0, w_s} * {17'b0, w_uw.ka};
    assign w_rhs = {14'b0, w_t} * {17'b0, w_uw.kb};
    assign w_cmp = w_uw.gt ? (w_lhs > w_rhs) : (w_lhs < w_rhs);
    assign w_lin = {3'b0, w_s} * 20'd5 + {9'b0, w_t, 1'b0};
    assign w_t5  = {3'b0, w_t} * 13'd5;
    assign w_big = (r_iv > $signed(cati_pkg::IV_BIG));

    always_comb begin
        if (r_f90) begin
            w_adj = 13'sd3;
        end else if (r_f50 && w_big) begin
            w_adj = 13'sd50;
        end else if (r_f80 && w_big) begin
            w_adj = 13'sd20;
        end else begin
            w_adj = 13'sd10;
        end
    end

    assign w_fin_iv  = (r_seen == 16'd0) ? cati_pkg::IV_SILENT : r_iv[11:0];
    assign w_fin_jit = (w_fin_iv[11:2] < cati_pkg::JIT_FLOOR) ? cati_pkg::JIT_FLOOR
                                                              : w_fin_iv[11:2];
    assign w_fin_int = (w_fin_iv < cati_pkg::IV_FLOOR) ? cati_pkg::IV_FLOOR : w_fin_iv;

    // divider requests from the microcode
    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = r_prod;
        w_req.divisor  = w_t5;
        w_req.last     = cati_pkg::DIV_LAST_LONG;
        case (w_uw.op)
            cati_pkg::OP_DIVQ: begin
                w_req.start    = r_run;
                w_req.dividend = {2'b0, w_t, 20'b0};
                w_req.divisor  = {5'b0, r_peers};
                w_req.last     = cati_pkg::DIV_LAST_SHORT;
            end
            cati_pkg::OP_DIVM: begin
                w_req.start    = r_run;
                w_req.dividend = {cati_pkg::IV_MAX, 20'b0};
                w_req.divisor  = w_quot[12:0];
                w_req.last     = cati_pkg::DIV_LAST_SHORT;
            end
            cati_pkg::OP_DIVP: begin
                w_req.start = r_run;
            end
            default: begin
            end
        endcase
    end

    cati_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_quot  (w_quot),
        .o_busy  (w_div_busy)
    );

    always_comb begin
        case (w_uw.cond)
            cati_pkg::C_NEXT:    w_cond = 1'b0;
            cati_pkg::C_JMP:     w_cond = 1'b1;
            cati_pkg::C_CMPF:    w_cond = !w_cmp;
            cati_pkg::C_PEERS0:  w_cond = (r_peers == 8'd0);
            cati_pkg::C_BUSY:    w_cond = w_div_busy;
            cati_pkg::C_QZERO:   w_cond = (w_quot == 32'd0);
            cati_pkg::C_OUTBUSY: w_cond = w_out_busy;
            default:             w_cond = 1'b0;
        endcase
    end

    always_comb begin
        n_target = r_target;
        n_iv     = r_iv;
        n_jitter = r_jitter;
        n_seen   = r_seen;
        n_own    = r_own;
        n_silent = r_silent;
        n_peers  = r_peers;
        n_f80    = r_f80;
        n_f50    = r_f50;
        n_f90    = r_f90;
        n_minv   = r_minv;
        n_prod   = r_prod;
        n_run    = r_run;
        n_pc     = r_pc;
        n_ovalid = r_ovalid;
        n_oint   = r_oint;
        n_ojit   = r_ojit;
        n_orst   = r_orst;

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_idx)
                cati_pkg::REG_TARGET:   n_target = i_cfg_data[9:0];
                cati_pkg::REG_INTERVAL: n_iv     = {1'b0, i_cfg_data};
                cati_pkg::REG_JITTER:   n_jitter = i_cfg_data[9:0];
                default: begin
                end
            endcase
        end

        if (w_in_acc) begin
            case (i_cmd)
                cati_pkg::CMD_EPOCH: begin
                    n_run   = 1'b1;
                    n_pc    = cati_pkg::L_START;
                    n_peers = i_active_peers;
                end
                cati_pkg::CMD_SEEN: begin
                    if (r_seen != 16'hFFFF) begin
                        n_seen = r_seen + 16'd1;
                    end
                end
                cati_pkg::CMD_OWN: begin
                    if (r_own != 16'hFFFF) begin
                        n_own = r_own + 16'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (r_run) begin
            n_pc = w_cond ? w_uw.target : r_pc + 5'd1;
            case (w_uw.op)
                cati_pkg::OP_CMP: begin
                    case (w_uw.flag)
                        cati_pkg::FLAG_80: n_f80 = w_cmp;
                        cati_pkg::FLAG_50: n_f50 = w_cmp;
                        cati_pkg::FLAG_90: n_f90 = w_cmp;
                        default: begin
                        end
                    endcase
                end
                cati_pkg::OP_HALVE: n_iv = r_iv >>> 1;
                cati_pkg::OP_TRIM: begin
                    if (r_own <= r_seen) begin
                        n_iv = r_iv - w_adj;
                    end
                end
                cati_pkg::OP_MINQ:  n_minv = w_quot[11:0];
                cati_pkg::OP_MIN1K: n_minv = cati_pkg::IV_SILENT;
                cati_pkg::OP_MIN4K: n_minv = cati_pkg::IV_MAX;
                cati_pkg::OP_CLAMP: begin
                    if (r_iv < $signed({1'b0, r_minv})) begin
                        n_iv = {1'b0, r_minv};
                    end
                end
                cati_pkg::OP_MUL: n_prod = {20'b0, r_iv[11:0]} * {12'b0, w_lin};
                cati_pkg::OP_SCALE: begin
                    if (w_quot == 32'd0) begin
                        n_iv = {1'b0, cati_pkg::IV_ZERO_SUB};
                    end else if (w_quot > {20'b0, cati_pkg::IV_MAX}) begin
                        n_iv = {1'b0, cati_pkg::IV_MAX};
                    end else begin
                        n_iv = {1'b0, w_quot[11:0]};
                    end
                end
                cati_pkg::OP_FIN: begin
                    if (!w_out_busy) begin
                        n_iv     = {1'b0, w_fin_int};
                        n_jitter = w_fin_jit;
                        n_oint   = w_fin_int;
                        n_ojit   = w_fin_jit;
                        n_orst   = 1'b0;
                        if (r_seen != 16'd0) begin
                            n_silent = 2'd0;
                        end else if (r_silent == 2'd3) begin
                            n_silent = 2'd0;
                            n_orst   = 1'b1;
                        end else begin
                            n_silent = r_silent + 2'd1;
                        end
                        n_seen   = 16'd0;
                        n_own    = 16'd0;
                        n_ovalid = 1'b1;
                        n_run    = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= cati_pkg::RST_TARGET;
            r_iv     <= {1'b0, cati_pkg::RST_INTERVAL};
            r_jitter <= cati_pkg::RST_JITTER;
            r_seen   <= '0;
            r_own    <= '0;
            r_silent <= '0;
            r_run    <= 1'b0;
            r_pc     <= cati_pkg::L_START;
            r_ovalid <= 1'b0;
        end else begin
            r_target <= n_target;
            r_iv     <= n_iv;
            r_jitter <= n_jitter;
            r_seen   <= n_seen;
            r_own    <= n_own;
            r_silent <= n_silent;
            r_run    <= n_run;
            r_pc     <= n_pc;
            r_ovalid <= n_ovalid;
        end
        r_peers <= n_peers;
        r_f80   <= n_f80;
        r_f50   <= n_f50;
        r_f90   <= n_f90;
        r_minv  <= n_minv;
        r_prod  <= n_prod;
        r_oint  <= n_oint;
        r_ojit  <= n_ojit;
        r_orst  <= n_orst;
    end

    assign o_stall       = r_run;
    assign o_valid       = r_ovalid;
    assign o_interval_ms = r_oint;
    assign o_jitter_ms   = r_ojit;
    assign o_reset_radio = r_orst;

    a_result_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_run))
        else $error("result raised without a running epoch update");

    a_reset_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_reset_radio) |-> (o_interval_ms == cati_pkg::IV_SILENT))
        else $error("radio reset request without silent interval");

    a_floors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_jitter_ms >= cati_pkg::JIT_FLOOR) &&
                     (o_interval_ms >= cati_pkg::IV_FLOOR)))
        else $error("result below floor");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_pc <= cati_pkg::L_FIN))
        else $error("step counter beyond program");

endmodule

// File: hdl/cati_div.sv
// iterative restoring divider, one quotient bit per cycle, 32 bit dividend, 13 bit divisor
// depends on cati_pkg for the request struct
module cati_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cati_pkg::t_div_req  i_req,
    output logic [31:0]         o_quot,
    output logic                o_busy
);

    logic        r_busy, n_busy;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_acc, n_acc;
    logic [12:0] r_rem, n_rem;
    logic [12:0] r_div, n_div;
    logic [13:0] w_trial;
    logic [13:0] w_diff;
    logic        w_ge;

    assign w_trial = {r_rem, r_acc[31]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.last;
            n_acc  = i_req.dividend;
            n_rem  = '0;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            n_acc = {r_acc[30:0], w_ge};
            n_rem = w_ge ? w_diff[12:0] : w_trial[12:0];
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_quot = r_acc;
    assign o_busy = r_busy;

endmodule
